### hw/rtl/sha1_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 digest block: the word queue
// entry, queue sizing and the initial chaining value.
// ----------------------------------------------------------------------------
package sha1_pkg;

  // word queue between the front and the back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // initial chaining value
  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // one big-endian message schedule word, with a flag on the last word of
  // the final block of a message
  typedef struct packed {
    logic        last_blk;
    logic [31:0] data;
  } qword_t;

endpackage
`default_nettype wire

### hw/rtl/sha1_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_front
// Accepts message bytes, packs them into big-endian words and pushes the
// words to the queue; on the end of a message it generates the padding
// words and the 64-bit bit length.
// ----------------------------------------------------------------------------
module sha1_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           in_byte_i,
  input  wire logic                 in_has_i,
  input  wire logic                 in_last_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output sha1_pkg::qword_t          push_word_o
);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_FIRST = 2'd1;
  localparam logic [1:0] F_FILL  = 2'd2;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [3:0] SLOT_LEN_HI = 4'd14;
  localparam logic [3:0] SLOT_LEN_LO = 4'd15;

  logic [1:0]  state_q, state_d;
  logic [60:0] count_q, count_d;
  logic [23:0] acc_q, acc_d;
  logic [3:0]  slot_q, slot_d;
  logic        len_blk_q, len_blk_d;
  logic        accept;

  assign in_ready_o = (state_q == F_IDLE) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // byte packing and padding sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    acc_d       = acc_q;
    slot_d      = slot_q;
    len_blk_d   = len_blk_q;
    push_o      = 1'b0;
    push_word_o = '0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (in_has_i) begin
            acc_d   = {acc_q[15:0], in_byte_i};
            count_d = count_q + 61'd1;
            if (count_q[1:0] == 2'd3) begin
              push_o           = 1'b1;
              push_word_o.data = {acc_q, in_byte_i};
            end
          end
          if (in_last_i) begin
            state_d = F_FIRST;
          end
        end
      end
      F_FIRST: begin
        // partial word closed by the pad byte; a pad word in either of the last
        // two slots leaves no room, so the next block carries the length
        if (!q_full_i) begin
          push_o = 1'b1;
          case (count_q[1:0])
            2'd0:    push_word_o.data = {PAD_BYTE, 24'h0};
            2'd1:    push_word_o.data = {acc_q[7:0], PAD_BYTE, 16'h0};
            2'd2:    push_word_o.data = {acc_q[15:0], PAD_BYTE, 8'h0};
            default: push_word_o.data = {acc_q[23:0], PAD_BYTE};
          endcase
          slot_d    = count_q[5:2] + 4'd1;
          len_blk_d = (count_q[5:2] < SLOT_LEN_HI) || (count_q[5:2] == SLOT_LEN_LO);
          state_d   = F_FILL;
        end
      end
      F_FILL: begin
        // zero fill, then the bit length in the last two slots
        if (!q_full_i) begin
          push_o = 1'b1;
          slot_d = slot_q + 4'd1;
          if (len_blk_q && (slot_q == SLOT_LEN_HI)) begin
            push_word_o.data = count_q[60:29];
          end else if (len_blk_q && (slot_q == SLOT_LEN_LO)) begin
            push_word_o.data     = {count_q[28:0], 3'b000};
            push_word_o.last_blk = 1'b1;
            count_d              = '0;
            state_d              = F_IDLE;
          end else if (slot_q == SLOT_LEN_LO) begin
            len_blk_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      count_q   <= '0;
      slot_q    <= '0;
      len_blk_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      slot_q    <= slot_d;
      len_blk_q <= len_blk_d;
    end
  end

  // partial word
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule
`default_nettype wire

### hw/rtl/sha1_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_queue
// Short first-in first-out queue of schedule words between the front and
// the back.
// ----------------------------------------------------------------------------
module sha1_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sha1_pkg::qword_t push_word_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  pop_valid_o,
  output sha1_pkg::qword_t      pop_word_o
);

  sha1_pkg::qword_t                  mem_q [sha1_pkg::QDEPTH];
  logic [sha1_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [sha1_pkg::QCNT_W-1:0]       cnt_q;
  logic                              do_push, do_pop;

  assign full_o      = cnt_q == sha1_pkg::QCNT_W'(sha1_pkg::QDEPTH);
  assign pop_valid_o = cnt_q != '0;
  assign pop_word_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sha1_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_back
// Runs the 80 SHA-1 rounds, one per cycle but stalled by an empty queue in
// the first sixteen, which take their schedule words from it; updates the
// chaining value; emits five digest words after a message's final block.
// ----------------------------------------------------------------------------
module sha1_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  input  wire sha1_pkg::qword_t pop_word_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [31:0]           out_word_o,
  output logic [2:0]            out_idx_o,
  output logic                  out_last_o
);

  localparam logic [1:0] B_ROUND  = 2'd0;
  localparam logic [1:0] B_FINISH = 2'd1;
  localparam logic [1:0] B_OUT    = 2'd2;

  localparam logic [6:0] R_LOAD = 7'd16;
  localparam logic [6:0] R_F2   = 7'd20;
  localparam logic [6:0] R_F3   = 7'd40;
  localparam logic [6:0] R_F4   = 7'd60;
  localparam logic [6:0] R_LAST = 7'd79;

  localparam logic [31:0] K1 = 32'h5A827999;
  localparam logic [31:0] K2 = 32'h6ED9EBA1;
  localparam logic [31:0] K3 = 32'h8F1BBCDC;
  localparam logic [31:0] K4 = 32'hCA62C1D6;

  localparam logic [2:0] IDX_LAST = 3'd4;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  logic [1:0]  state_q;
  logic [6:0]  round_q;
  logic        fin_q;
  logic [2:0]  oidx_q;
  logic [31:0] chain_q [5];
  logic [31:0] win_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  logic [31:0] a_in, b_in, c_in, d_in, e_in;
  logic [31:0] w_gen, w_t, f, k, t;
  logic        first_round, loading, step, out_load;

  assign first_round = round_q == '0;
  assign loading     = round_q < R_LOAD;
  assign step        = (state_q == B_ROUND) && (!loading || pop_valid_i);
  assign pop_o       = (state_q == B_ROUND) && loading && pop_valid_i;
  assign out_load    = (state_q == B_OUT) && (!out_valid_q || out_ready_i);

  // working variables start from the chaining value
  assign a_in = first_round ? chain_q[0] : a_q;
  assign b_in = first_round ? chain_q[1] : b_q;
  assign c_in = first_round ? chain_q[2] : c_q;
  assign d_in = first_round ? chain_q[3] : d_q;
  assign e_in = first_round ? chain_q[4] : e_q;

  // message schedule
  assign w_gen = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
  assign w_t   = loading ? pop_word_i.data : w_gen;

  // round function and constant
  always_comb begin
    if (round_q < R_F2) begin
      f = (b_in & c_in) | (~b_in & d_in);
      k = K1;
    end else if (round_q < R_F3) begin
      f = b_in ^ c_in ^ d_in;
      k = K2;
    end else if (round_q < R_F4) begin
      f = (b_in & c_in) | (b_in & d_in) | (c_in & d_in);
      k = K3;
    end else begin
      f = b_in ^ c_in ^ d_in;
      k = K4;
    end
  end

  assign t = rotl(a_in, 5) + f + e_in + k + w_t;

  // sequencer, chaining value and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_ROUND;
      round_q     <= '0;
      fin_q       <= 1'b0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < 5; j++) begin
        chain_q[j] <= sha1_pkg::IV[j];
      end
    end else begin
      case (state_q)
        B_ROUND: begin
          if (step) begin
            if (round_q == R_LOAD - 7'd1) begin
              fin_q <= pop_word_i.last_blk;
            end
            if (round_q == R_LAST) begin
              round_q <= '0;
              state_q <= B_FINISH;
            end else begin
              round_q <= round_q + 7'd1;
            end
          end
        end
        B_FINISH: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
          oidx_q     <= '0;
          state_q    <= fin_q ? B_OUT : B_ROUND;
        end
        B_OUT: begin
          if (out_load) begin
            if (oidx_q == IDX_LAST) begin
              for (int j = 0; j < 5; j++) begin
                chain_q[j] <= sha1_pkg::IV[j];
              end
              state_q <= B_ROUND;
            end else begin
              oidx_q <= oidx_q + 3'd1;
            end
          end
        end
        default: begin
          state_q <= B_ROUND;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // schedule window, working variables and output data
  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int j = 0; j < 15; j++) begin
        win_q[j] <= win_q[j+1];
      end
      win_q[15] <= w_t;
      a_q <= t;
      b_q <= a_in;
      c_q <= rotl(b_in, 30);
      d_q <= c_in;
      e_q <= d_in;
    end
    if (out_load) begin
      out_word_q <= chain_q[oidx_q];
      out_idx_q  <= oidx_q;
      out_last_q <= oidx_q == IDX_LAST;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_idx_o   = out_idx_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

### hw/rtl/sha1_message_digest.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream: at most one byte per item, five digest
// words out after the item marked last.
// Throughput: one byte per cycle while the word queue has room and no
// padding is being generated; each 64-byte block takes 80 rounds and one
// chaining add in the round engine, and the input stalls once the queue
// fills during rounds 16 to 79.
// After the last item, the one or two padded blocks, behind any earlier
// block still in the round engine, run before the first digest word; the
// other four follow one per cycle while the digest side accepts them.
// Reset clears all control state and loads the initial vector.
// ----------------------------------------------------------------------------
module sha1_message_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast    // last_word
);

  logic             push, q_full, pop, pop_valid;
  sha1_pkg::qword_t push_word, pop_word;

  // byte packing and padding
  sha1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_has_i    (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  // word queue
  sha1_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_word_o  (pop_word)
  );

  // round engine and digest output
  sha1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_word_i  (pop_word),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata),
    .out_idx_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

### tb/sha1_digest_checker.sv
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches the byte and digest channels of the SHA-1 block. Every accepted
// byte item is run through a behavioral SHA-1 model, which queues the five
// digest words of each finished message; each accepted digest word is
// compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_has_byte_i,
  input  logic              in_last_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [31:0]       out_word_i,
  input  logic [2:0]        out_index_i,
  input  logic              out_last_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam logic [31:0] START_CHAIN [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_P2  = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // model state
  logic [31:0]  chain_q [5];
  logic [7:0]   block_q [64];
  logic [60:0]  byte_total;
  digest_word_t digest_words_q [$];

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // 80 rounds over the current block, added into the chaining value
  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, t, mix;
    int unsigned slot;
    for (int j = 0; j < 16; j++)
      sched[j] = {block_q[4*j], block_q[4*j+1], block_q[4*j+2], block_q[4*j+3]};
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int r = 0; r < 80; r++) begin
      slot = r % 16;
      if (r >= 16) begin
        mix = sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^ sched[(r + 2) % 16] ^ sched[slot];
        sched[slot] = rotl(mix, 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_P1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_P2;
      end
      t = rotl(a, 5) + f + e + k + sched[slot];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
    chain_q[4] += e;
  endfunction

  function automatic void clear_model();
    foreach (chain_q[j]) chain_q[j] = START_CHAIN[j];
    foreach (block_q[j]) block_q[j] = '0;
    byte_total = '0;
  endfunction

  // take one byte item; on the end of a message pad and queue the digest
  function automatic void absorb_item(input logic [7:0] data, input logic has_byte,
                                      input logic is_last);
    int unsigned  pos;
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (has_byte) begin
      pos = byte_total[5:0];
      block_q[pos] = data;
      byte_total = byte_total + 61'd1;
      if (pos == 63) compress_block();
    end
    if (!is_last) return;
    pos = byte_total[5:0];
    block_q[pos] = PAD_MARK;
    for (int j = pos + 1; j < 64; j++) block_q[j] = '0;
    if (pos >= 56) begin
      compress_block();
      foreach (block_q[j]) block_q[j] = '0;
    end
    bit_len = {byte_total, 3'b000};
    for (int j = 0; j < 8; j++) block_q[63 - j] = bit_len[8*j +: 8];
    compress_block();
    for (int j = 0; j < 5; j++) begin
      dw.word  = chain_q[j];
      dw.index = 3'(j);
      dw.last  = (j == 4);
      digest_words_q.push_back(dw);
    end
    foreach (chain_q[j]) chain_q[j] = START_CHAIN[j];
    byte_total = '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    clear_model();
  end

  // compare digest words first, then absorb the byte item of the same edge
  always @(posedge clk_i) begin
    digest_word_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (digest_words_q.size() == 0) begin
          report_mismatch("digest word with none pending", out_word_i, '0);
        end else begin
          want = digest_words_q.pop_front();
          if (out_word_i !== want.word)
            report_mismatch("digest_word", out_word_i, want.word);
          if (out_index_i !== want.index)
            report_mismatch("word_index", 32'(out_index_i), 32'(want.index));
          if (out_last_i !== want.last)
            report_mismatch("last_word", 32'(out_last_i), 32'(want.last));
        end
      end
      if (in_valid_i && in_ready_i)
        absorb_item(in_byte_i, in_has_byte_i, in_last_i);
      pending_o = digest_words_q.size();
    end
  end

endmodule

### tb/sha1_message_digest_test.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_test
// Stimulus for the SHA-1 digest block: directed corner messages, a phase
// with the digest side held off so the block backs up, then random messages
// under several idle and stall mixes. A checker instance predicts and
// compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module sha1_message_digest_test;

  localparam int unsigned ITEMS_PER_PHASE = 28;
  localparam int unsigned HOLD_CYCLES     = 1500;
  localparam int unsigned DRAIN_CYCLES    = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] msg_byte
  logic        s_axis_tuser;   // [0] has_byte
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] digest_word
  logic [2:0]  m_axis_tuser;   // [2:0] word_index
  logic        m_axis_tlast;   // last_word

  int unsigned fail_count;
  int unsigned pending_words;

  // idle mix, written only by the stimulus process
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_requests;
  int unsigned sent_items;

  sha1_message_digest i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sha1_digest_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .in_has_byte_i (s_axis_tuser),
    .in_last_i     (s_axis_tlast),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_word_i    (m_axis_tdata),
    .out_index_i   (m_axis_tuser),
    .out_last_i    (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // digest side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left = 0;
    holds_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // offer one item at a falling edge and wait for its handshake
  task automatic send_item(input logic [7:0] data, input logic has_byte,
                           input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (has_byte || is_last) sent_items++;
  endtask

  // random bytes with a few empty steps mixed in; the end either rides on
  // the last byte or comes as a separate empty end marker
  task automatic send_message(input int unsigned len);
    logic end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(10);
    if (roll < 90) return $urandom_range(66, 52);
    return $urandom_range(130, 100);
  endfunction

  initial begin
    int unsigned phase_start;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_requests = 0;
    sent_items    = 0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty step, then the empty message
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // "abc" with an empty step inside and the end on the final byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // extreme bytes closed by an empty end marker
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    // single byte message with the end on it
    send_item(8'hFF, 1'b1, 1'b1);
    // assorted bit patterns
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);

    // digest side held off while messages that need two padded blocks and
    // one full block keep coming, so the block backs up into its input
    hold_requests++;
    send_message(56);
    send_message(64);
    send_message(3);

    // random messages under each idle mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 83;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 83;
        end
        default: begin
          tx_idle_pct = 8;
          rx_stall_pct = 8;
        end
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < ITEMS_PER_PHASE) send_message(pick_length());
    end
    s_axis_tvalid <= 1'b0;

    // drain the outstanding digest words, then watch for strays
    while (pending_words != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_front.sv
hw/rtl/sha1_queue.sv
hw/rtl/sha1_back.sv
hw/rtl/sha1_message_digest.sv
tb/sha1_digest_checker.sv
tb/sha1_message_digest_test.sv
